FILE: sv/primorial_sieve_start_offset_assert.svh
// Assertion macros shared by the block's RTL files.
`ifndef PRIMORIAL_SIEVE_START_OFFSET_ASSERT_SVH
`define PRIMORIAL_SIEVE_START_OFFSET_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/pss_pkg.sv
package pss_pkg;

  // Data widths: modulus and results, and the signed Bezout coefficients.
  localparam int unsigned W    = 32;
  localparam int unsigned DW   = 2 * W;
  localparam int unsigned TW   = W + 2;
  localparam int unsigned CNTW = 6;

  // Factors whose product is the primorial 100#.
  localparam logic [W-1:0]  F0  = 32'd223092870;
  localparam logic [W-1:0]  F1  = 32'd2756205443;
  localparam logic [W-1:0]  F2  = 32'd907383479;
  localparam logic [W-1:0]  F3  = 32'd4132280413;
  localparam logic [DW-1:0] F01 = 64'(F0) * 64'(F1);

  // Step counts of the shift-subtract divider, minus one.
  localparam logic [CNTW-1:0] RED_STEPS_M1 = 6'd63;
  localparam logic [CNTW-1:0] EU_STEPS_M1  = 6'd31;

  // Last reduction stage index.
  localparam logic [1:0] LAST_STAGE = 2'd2;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_STEP,
    CMD_RED_MUL,
    CMD_EU_INIT,
    CMD_EU_DIV,
    CMD_EU_MUL,
    CMD_EU_UPD,
    CMD_FINAL,
    CMD_FAIL
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e op;
    logic    sel_f3;
  } cmd_t;

  typedef struct packed {
    logic p_small;
    logic res_zero;
    logic nr_zero;
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_DIV,
    S_RED_MUL,
    S_EU_INIT,
    S_EU_CHECK,
    S_EU_DIV,
    S_EU_MUL,
    S_EU_UPD,
    S_FINAL,
    S_FAIL
  } state_e;

endpackage

FILE: sv/pss_dp.sv
module pss_dp (
  input  logic                      clk_i,
  input  pss_pkg::cmd_t             cmd_i,
  input  logic [pss_pkg::W-1:0]     modulus_i,
  output pss_pkg::status_t          status_o,
  output logic [pss_pkg::W-1:0]     start_index_o,
  output logic [pss_pkg::W-1:0]     inverse_value_o,
  output logic                      has_inverse_o
);

  localparam int unsigned W  = pss_pkg::W;
  localparam int unsigned DW = pss_pkg::DW;
  localparam int unsigned TW = pss_pkg::TW;

  logic [W-1:0]         p_q, p_d;
  logic [W:0]           rem_q, rem_d;
  logic [DW-1:0]        sh_q, sh_d;
  logic [W-1:0]         dvs_q, dvs_d;
  logic [W-1:0]         r_q, r_d, nr_q, nr_d;
  logic signed [TW-1:0] t_q, t_d, nt_q, nt_d, prod_q, prod_d;
  logic [W-1:0]         start_q, start_d, inv_q, inv_d;
  logic                 ok_q, ok_d;

  logic [W:0]             cand, diff;
  logic [W-1:0]           factor;
  logic signed [W:0]      q_s;
  logic signed [2*TW-1:0] prod_full;
  logic signed [TW-1:0]   t_adj;
  logic [W-1:0]           inv_c;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  assign cand = {rem_q[W-1:0], sh_q[DW-1]};
  assign diff = cand - {1'b0, dvs_q};

  assign factor    = cmd_i.sel_f3 ? pss_pkg::F3 : pss_pkg::F2;
  assign q_s       = $signed({1'b0, sh_q[W-1:0]});
  assign prod_full = q_s * nt_q;

  // Final correction of a negative coefficient into 0..p-1.
  assign t_adj = t_q[TW-1] ? t_q + $signed({2'b00, p_q}) : t_q;
  assign inv_c = t_adj[W-1:0];

  always_comb begin
    p_d     = p_q;
    rem_d   = rem_q;
    sh_d    = sh_q;
    dvs_d   = dvs_q;
    r_d     = r_q;
    nr_d    = nr_q;
    t_d     = t_q;
    nt_d    = nt_q;
    prod_d  = prod_q;
    start_d = start_q;
    inv_d   = inv_q;
    ok_d    = ok_q;
    case (cmd_i.op)
      pss_pkg::CMD_LOAD: begin
        p_d   = modulus_i;
        dvs_d = modulus_i;
        sh_d  = pss_pkg::F01;
        rem_d = '0;
      end
      pss_pkg::CMD_STEP: begin
        if (!diff[W]) begin
          rem_d = diff;
        end else begin
          rem_d = cand;
        end
        sh_d = {sh_q[DW-2:0], ~diff[W]};
      end
      pss_pkg::CMD_RED_MUL: begin
        sh_d  = {{W{1'b0}}, rem_q[W-1:0]} * {{W{1'b0}}, factor};
        rem_d = '0;
      end
      pss_pkg::CMD_EU_INIT: begin
        r_d  = p_q;
        nr_d = rem_q[W-1:0];
        t_d  = '0;
        nt_d = TW'(1);
      end
      pss_pkg::CMD_EU_DIV: begin
        sh_d  = {r_q, {W{1'b0}}};
        dvs_d = nr_q;
        rem_d = '0;
      end
      pss_pkg::CMD_EU_MUL: begin
        prod_d = $signed(prod_full[TW-1:0]);
      end
      pss_pkg::CMD_EU_UPD: begin
        t_d  = nt_q;
        nt_d = t_q - prod_q;
        r_d  = nr_q;
        nr_d = rem_q[W-1:0];
      end
      pss_pkg::CMD_FINAL: begin
        if ((r_q == W'(1)) && (inv_c != '0)) begin
          ok_d    = 1'b1;
          inv_d   = inv_c;
          start_d = p_q - inv_c;
        end else begin
          ok_d    = 1'b0;
          inv_d   = '0;
          start_d = '0;
        end
      end
      pss_pkg::CMD_FAIL: begin
        ok_d    = 1'b0;
        inv_d   = '0;
        start_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    rem_q   <= rem_d;
    sh_q    <= sh_d;
    dvs_q   <= dvs_d;
    r_q     <= r_d;
    nr_q    <= nr_d;
    t_q     <= t_d;
    nt_q    <= nt_d;
    prod_q  <= prod_d;
    start_q <= start_d;
    inv_q   <= inv_d;
    ok_q    <= ok_d;
  end

  assign status_o.p_small  = (p_q[W-1:1] == '0);
  assign status_o.res_zero = (rem_q == '0);
  assign status_o.nr_zero  = (nr_q == '0);

  assign start_index_o   = start_q;
  assign inverse_value_o = inv_q;
  assign has_inverse_o   = ok_q;

endmodule

FILE: sv/pss_ctrl.sv
module pss_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  pss_pkg::status_t status_i,
  output pss_pkg::cmd_t    cmd_o
);

  pss_pkg::state_e             state_q, state_d;
  logic [pss_pkg::CNTW-1:0]    cnt_q, cnt_d;
  logic [1:0]                  stage_q, stage_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_free;

  // The result register may be refilled when empty or being emptied.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pss_pkg::S_IDLE;
      cnt_q       <= '0;
      stage_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      stage_q     <= stage_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sequencer for reduction, Euclid iterations and result write.
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    stage_d      = stage_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cmd_o.op     = pss_pkg::CMD_NONE;
    cmd_o.sel_f3 = (stage_q == pss_pkg::LAST_STAGE);
    in_ready_o   = 1'b0;
    case (state_q)
      pss_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = pss_pkg::CMD_LOAD;
          cnt_d    = pss_pkg::RED_STEPS_M1;
          stage_d  = '0;
          state_d  = pss_pkg::S_RED_DIV;
        end
      end
      pss_pkg::S_RED_DIV: begin
        cmd_o.op = pss_pkg::CMD_STEP;
        cnt_d    = cnt_q - pss_pkg::CNTW'(1);
        if (cnt_q == '0) begin
          if (stage_q == pss_pkg::LAST_STAGE) begin
            state_d = pss_pkg::S_EU_INIT;
          end else begin
            stage_d = stage_q + 2'd1;
            state_d = pss_pkg::S_RED_MUL;
          end
        end
      end
      pss_pkg::S_RED_MUL: begin
        cmd_o.op = pss_pkg::CMD_RED_MUL;
        cnt_d    = pss_pkg::RED_STEPS_M1;
        state_d  = pss_pkg::S_RED_DIV;
      end
      pss_pkg::S_EU_INIT: begin
        if (status_i.p_small || status_i.res_zero) begin
          state_d = pss_pkg::S_FAIL;
        end else begin
          cmd_o.op = pss_pkg::CMD_EU_INIT;
          state_d  = pss_pkg::S_EU_CHECK;
        end
      end
      pss_pkg::S_EU_CHECK: begin
        if (status_i.nr_zero) begin
          state_d = pss_pkg::S_FINAL;
        end else begin
          cmd_o.op = pss_pkg::CMD_EU_DIV;
          cnt_d    = pss_pkg::EU_STEPS_M1;
          state_d  = pss_pkg::S_EU_DIV;
        end
      end
      pss_pkg::S_EU_DIV: begin
        cmd_o.op = pss_pkg::CMD_STEP;
        cnt_d    = cnt_q - pss_pkg::CNTW'(1);
        if (cnt_q == '0) begin
          state_d = pss_pkg::S_EU_MUL;
        end
      end
      pss_pkg::S_EU_MUL: begin
        cmd_o.op = pss_pkg::CMD_EU_MUL;
        state_d  = pss_pkg::S_EU_UPD;
      end
      pss_pkg::S_EU_UPD: begin
        cmd_o.op = pss_pkg::CMD_EU_UPD;
        state_d  = pss_pkg::S_EU_CHECK;
      end
      pss_pkg::S_FINAL: begin
        if (out_free) begin
          cmd_o.op    = pss_pkg::CMD_FINAL;
          out_valid_d = 1'b1;
          state_d     = pss_pkg::S_IDLE;
        end
      end
      pss_pkg::S_FAIL: begin
        if (out_free) begin
          cmd_o.op    = pss_pkg::CMD_FAIL;
          out_valid_d = 1'b1;
          state_d     = pss_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pss_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/primorial_sieve_start_offset.sv
// For each request carrying a modulus p, the block reduces the primorial
// 100# modulo p and inverts that residue, then returns the inverse, a flag
// telling whether it exists, and the first k with k*100#+1 divisible by p
// (p minus the inverse, or 0 when there is none). One request is worked on
// at a time. A shared shift-subtract divider does the work: the three
// reductions run on it with a multiply between each two of them, and each
// extended Euclid iteration then runs 32 divider steps, a multiply, an
// update and a check, with at most about 46 iterations for a 32-bit
// modulus. A request that fails early (p below 2 or a zero residue)
// finishes right after the reductions. The result sits in an output
// register, so a new request can be accepted while the previous result
// still waits to be taken.
`include "primorial_sieve_start_offset_assert.svh"

module primorial_sieve_start_offset (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] modulus_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] start_index_o,
  output logic [31:0] inverse_value_o,
  output logic        has_inverse_o
);

  pss_pkg::cmd_t    cmd;
  pss_pkg::status_t status;

  // Sequencer.
  pss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Divider, coefficient registers and result register.
  pss_dp u_dp (
    .clk_i           (clk_i),
    .cmd_i           (cmd),
    .modulus_i       (modulus_i),
    .status_o        (status),
    .start_index_o   (start_index_o),
    .inverse_value_o (inverse_value_o),
    .has_inverse_o   (has_inverse_o)
  );

  // A request starts a long computation, so the input side is busy next.
  `PSS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o,
                   "ready after accept")
  // A failed result carries zero fields.
  `PSS_ASSERT_NOW(a_fail_zero, out_valid_o && !has_inverse_o,
                  (start_index_o == '0) && (inverse_value_o == '0),
                  "nonzero fields without inverse")
  // A valid inverse is never zero.
  `PSS_ASSERT_NOW(a_inv_nonzero, out_valid_o && has_inverse_o, inverse_value_o != '0,
                  "zero inverse flagged valid")

endmodule

FILE: tb/tb.sv
module tb;

  // Result fields of one request, in port order.
  typedef struct packed {
    logic [31:0] start_index;
    logic [31:0] inverse_value;
    logic        has_inverse;
  } sieve_offset_t;

  // Factors whose product is the primorial 100#.
  localparam logic [63:0] PRIM_A = 64'd223092870;
  localparam logic [63:0] PRIM_B = 64'd2756205443;
  localparam logic [63:0] PRIM_C = 64'd907383479;
  localparam logic [63:0] PRIM_D = 64'd4132280413;

  localparam int unsigned RANDOM_IDLE_ITEMS  = 250;
  localparam int unsigned RANDOM_STEADY_ITEMS = 150;
  localparam int unsigned LONG_HOLD_CYCLES   = 6000;
  localparam int unsigned DRAIN_CYCLES       = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [31:0] modulus = 32'd0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [31:0] start_index;
  logic [31:0] inverse_value;
  logic        has_inverse;

  sieve_offset_t pending_offsets[$];
  int unsigned   error_count = 0;
  bit            idle_en = 1'b0;
  int unsigned   long_hold_req = 0;
  int unsigned   rx_stall = 0;

  always #2 clk_i = ~clk_i;

  primorial_sieve_start_offset u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .modulus_i      (modulus),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .start_index_o  (start_index),
    .inverse_value_o(inverse_value),
    .has_inverse_o  (has_inverse)
  );

  // Reduce 100# modulo p, invert the residue by extended Euclid, and derive
  // the first k with k*100#+1 divisible by p.
  function automatic sieve_offset_t predict_start_offset(input logic [31:0] p);
    logic [63:0]   m;
    logic [63:0]   res;
    logic [63:0]   r;
    logic [63:0]   nr;
    logic [63:0]   q;
    logic [63:0]   y;
    longint        t;
    longint        nt;
    longint        x;
    sieve_offset_t o;
    o = '0;
    m = {32'd0, p};
    if (m >= 64'd2) begin
      res = (PRIM_A * PRIM_B) % m;
      res = (res * PRIM_C) % m;
      res = (res * PRIM_D) % m;
      if (res != 64'd0) begin
        r  = m;
        nr = res;
        t  = 0;
        nt = 1;
        while (nr != 64'd0) begin
          q  = r / nr;
          x  = t - longint'(q) * nt;
          y  = r - q * nr;
          t  = nt;
          nt = x;
          r  = nr;
          nr = y;
        end
        // Only a gcd of one gives an inverse.
        if (r == 64'd1) begin
          if (t < 0) begin
            t += longint'(m);
          end
          o.has_inverse   = 1'b1;
          o.inverse_value = t[31:0];
          o.start_index   = p - t[31:0];
        end
      end
    end
    return o;
  endfunction

  // Offer one request and record its expected result once it is accepted.
  task automatic send_modulus(input logic [31:0] p);
    int unsigned gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
    end
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    modulus  <= p;
    do @(posedge clk_i); while (!in_ready);
    pending_offsets.push_back(predict_start_offset(p));
  endtask

  // Stop offering requests and wait until every result has come back.
  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_offsets.size() != 0) @(posedge clk_i);
  endtask

  // Mostly odd moduli of full width, with small and arbitrary ones mixed in
  // so that zero residues, shared factors and even values keep coming up.
  function automatic logic [31:0] random_modulus();
    logic [31:0] p;
    case ($urandom_range(0, 9))
      0: begin
        p = $urandom_range(0, 2000);
      end
      1: begin
        p = $urandom;
      end
      2: begin
        p = $urandom_range(3, 200000) | 32'd1;
      end
      default: begin
        p = $urandom | 32'd1;
      end
    endcase
    return p;
  endfunction

  task automatic test_special_moduli();
    logic [31:0] list[$];
    list = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd97, 32'd101, 32'd103, 32'd303, 32'd505,
             32'd10403, 32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
             32'd4294967291, 32'd2756205443, 32'd4132280413, 32'd907383479,
             32'h5555_5555, 32'hAAAA_AAAA, 32'd9699691};
    foreach (list[i]) begin
      send_modulus(list[i]);
    end
    wait_for_results();
  endtask

  task automatic test_random_moduli(input int unsigned count);
    repeat (count) send_modulus(random_modulus());
  endtask

  // Hold the output off long enough that the block fills and stalls its input.
  task automatic test_output_backpressure();
    @(posedge clk_i);
    long_hold_req = LONG_HOLD_CYCLES;
    send_modulus(32'd3);
    send_modulus(32'd97);
    send_modulus(32'd101);
    send_modulus($urandom | 32'd1);
    send_modulus(32'd4294967291);
    send_modulus(32'd5);
    wait_for_results();
  endtask

  // Drive the result side: long holds on request, random stall bursts.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (long_hold_req != 0) begin
      rx_stall = long_hold_req;
      long_hold_req = 0;
      out_ready <= 1'b0;
    end else if (rx_stall != 0) begin
      rx_stall = rx_stall - 1;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      rx_stall = $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic report_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    sieve_offset_t exp_r;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_offsets.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d %0d %0b", $time,
                 start_index, inverse_value, has_inverse);
        error_count++;
      end else begin
        exp_r = pending_offsets.pop_front();
        report_field("start_index", exp_r.start_index, start_index);
        report_field("inverse_value", exp_r.inverse_value, inverse_value);
        report_field("has_inverse", {31'd0, exp_r.has_inverse}, {31'd0, has_inverse});
      end
    end
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    idle_en = 1'b1;
    test_special_moduli();
    test_random_moduli(RANDOM_IDLE_ITEMS / 2);
    test_output_backpressure();
    test_random_moduli(RANDOM_IDLE_ITEMS / 2);
    // Final stretch runs with both sides always ready.
    idle_en = 1'b0;
    test_random_moduli(RANDOM_STEADY_ITEMS);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
